// ----- rtl/core/smts_pkg.sv -----
// ----------------------------------------------------------------------------
// smts_pkg: shared types and constants of the star magnitude to sprite core
// Field widths, fixed-point constants, payload structs and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package smts_pkg;

  // Field and datapath widths.
  localparam int unsigned IdxW   = 9;
  localparam int unsigned OffW   = 21;
  localparam int unsigned StepW  = 17;
  localparam int unsigned CfgW   = 21;
  localparam int unsigned LnW    = 27;
  localparam int unsigned NW     = 10;
  localparam int unsigned FracW  = 30;
  localparam int unsigned SumW   = 32;
  localparam int unsigned RadW   = 24;
  localparam int unsigned RootW  = 20;
  localparam int unsigned SqInW  = 40;
  localparam int unsigned GrayW  = 8;
  localparam int unsigned DrawW  = 16;
  localparam int unsigned TermN  = 13;

  // Highest magnitude index; larger indexes are clamped to it.
  localparam logic [IdxW-1:0] IndexMax = 9'd256;

  // Log radius at which the raw radius reaches 256 pixels (Q.16).
  localparam logic signed [LnW-1:0] LnSat = 27'sd363410;
  // ln(2) in Q30 and 2^32 / (ln(2) * 2^16) for the quotient estimate.
  localparam logic [FracW-1:0] Ln2Q30 = 30'd744261118;
  localparam logic [17:0]      InvLn2 = 18'd94548;

  // Radius thresholds in Q8.16; HalfMin is a drawn radius in Q8.8.
  localparam logic [RadW-1:0] RMax    = 24'hFFFFFF;
  localparam logic [RadW-1:0] RMinVis = 24'd19660;
  localparam logic [RadW-1:0] RSmall  = 24'd78643;
  localparam logic [RadW-1:0] RBig    = 24'd524288;
  localparam logic [RadW-1:0] RSeven  = 24'd458752;
  localparam logic [DrawW-1:0] HalfMin = 16'd154;

  // Cube tests and gray level scaling.
  localparam logic [63:0] FaintLim  = 64'h0036_0000_0000_0000;
  localparam logic [63:0] GrayBias  = 64'h0024_0000_0000_0000;
  localparam logic [13:0] GrayMul   = 14'd10625;
  localparam logic [9:0]  FaintMul  = 10'd625;
  localparam logic [12:0] Div9Mul   = 13'd7282;

  // Configuration register indexes.
  typedef enum logic {
    RegOffset = 1'b0,
    RegStep   = 1'b1
  } smts_reg_e;

  // Input item.
  typedef struct packed {
    logic [IdxW-1:0] mag_idx;
  } smts_in_t;

  // Result item.
  typedef struct packed {
    logic             visible;
    logic [DrawW-1:0] draw_radius;
    logic [GrayW-1:0] gray_level;
  } smts_out_t;

  // Shading result carried alongside the square root.
  typedef struct packed {
    logic             vis;
    logic             small_r;
    logic [GrayW-1:0] gray;
    logic [RadW-1:0]  rad;
  } smts_side_t;

endpackage

`default_nettype wire

// ----- rtl/core/smts_stream_if.sv -----
// ----------------------------------------------------------------------------
// smts_stream_if: valid/ready channel
// Carries one item per handshake; payload type is set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface smts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/smts_exp.sv -----
// ----------------------------------------------------------------------------
// smts_exp: pipelined exponential of a Q.16 log radius
// Range reduction by ln(2), a Taylor series up to f^13 and a final scaling
// give the raw radius in Q8.16, saturated at 0xFFFFFF.
// ----------------------------------------------------------------------------
`default_nettype none

module smts_exp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                en_i,
  input  wire                                vld_i,
  input  wire logic signed [smts_pkg::LnW-1:0] ln_i,
  output logic                               vld_o,
  output logic [smts_pkg::RadW-1:0]          rad_o
);
  import smts_pkg::*;

  // Stage 1: saturation test and estimate of n = floor(L / ln2).
  logic signed [LnW+18:0] n_prod;
  logic                   s1_vld_q;
  logic signed [LnW-1:0]  s1_ln_q;
  logic signed [NW-1:0]   s1_n_q;
  logic                   s1_sat_q;

  assign n_prod = ln_i * $signed({1'b0, InvLn2});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ln_q  <= ln_i;
      s1_n_q   <= n_prod[NW+31:32];
      s1_sat_q <= (ln_i >= LnSat);
    end
  end

  // Stage 2: remainder of the reduction, possibly one ln2 off.
  logic signed [LnW+13:0] lq;
  logic signed [NW+30:0]  nl;
  logic signed [41:0]     f_raw;
  logic                   s2_vld_q;
  logic signed [41:0]     s2_f_q;
  logic signed [NW-1:0]   s2_n_q;
  logic                   s2_sat_q;

  assign lq    = $signed({s1_ln_q, 14'd0});
  assign nl    = s1_n_q * $signed({1'b0, Ln2Q30});
  assign f_raw = 42'(lq) - 42'(nl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_f_q   <= f_raw;
      s2_n_q   <= s1_n_q;
      s2_sat_q <= s1_sat_q;
    end
  end

  // Stage 3: correct the estimate and start the series with 1 + f.
  logic signed [41:0]   ln2_s;
  logic signed [41:0]   f_fix;
  logic signed [NW-1:0] n_fix;

  logic [TermN-1:0]     t_vld_q;
  logic [FracW-1:0]     t_f_q    [TermN];
  logic [FracW-1:0]     t_term_q [TermN];
  logic [SumW-1:0]      t_sum_q  [TermN];
  logic signed [NW-1:0] t_n_q    [TermN];
  logic                 t_sat_q  [TermN];

  assign ln2_s = $signed(42'(Ln2Q30));

  always_comb begin
    if (s2_f_q < 42'sd0) begin
      f_fix = s2_f_q + ln2_s;
      n_fix = s2_n_q - NW'(1);
    end else if (s2_f_q >= ln2_s) begin
      f_fix = s2_f_q - ln2_s;
      n_fix = s2_n_q + NW'(1);
    end else begin
      f_fix = s2_f_q;
      n_fix = s2_n_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      t_vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_f_q[0]    <= f_fix[FracW-1:0];
      t_term_q[0] <= f_fix[FracW-1:0];
      t_sum_q[0]  <= (SumW'(1) << FracW) + SumW'(f_fix[FracW-1:0]);
      t_n_q[0]    <= n_fix;
      t_sat_q[0]  <= s2_sat_q;
    end
  end

  // Taylor terms 2 to 13: multiply by f, then divide by k through its
  // reciprocal, which is exact for 30-bit terms.
  for (genvar g = 0; g < TermN - 1; g++) begin : g_term
    localparam int unsigned K = g + 2;
    localparam logic [34:0] Mk = 35'(((65'd1 << 34) + 65'(K) - 65'd1) / 65'(K));

    logic [2*FracW-1:0] pa;
    logic [FracW+34:0]  pb;
    logic               a_vld_q;
    logic [FracW-1:0]   a_f_q;
    logic [FracW-1:0]   a_p_q;
    logic [SumW-1:0]    a_sum_q;
    logic signed [NW-1:0] a_n_q;
    logic               a_sat_q;

    assign pa = (2*FracW)'(t_term_q[g]) * (2*FracW)'(t_f_q[g]);
    assign pb = (FracW+35)'(a_p_q) * (FracW+35)'(Mk);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q      <= 1'b0;
        t_vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        a_vld_q      <= t_vld_q[g];
        t_vld_q[g+1] <= a_vld_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_f_q          <= t_f_q[g];
        a_p_q          <= pa[2*FracW-1:FracW];
        a_sum_q        <= t_sum_q[g];
        a_n_q          <= t_n_q[g];
        a_sat_q        <= t_sat_q[g];
        t_f_q[g+1]     <= a_f_q;
        t_term_q[g+1]  <= pb[FracW+33:34];
        t_sum_q[g+1]   <= a_sum_q + SumW'(pb[FracW+33:34]);
        t_n_q[g+1]     <= a_n_q;
        t_sat_q[g+1]   <= a_sat_q;
      end
    end
  end

  // Final stage: scale by 2^(n-14) and saturate.
  logic signed [NW:0] sh;
  logic               sh_big;
  logic [SumW-1:0]    shifted;
  logic [RadW-1:0]    rad_d;

  assign sh      = (NW+1)'(14) - (NW+1)'(t_n_q[TermN-1]);
  assign sh_big  = (sh > $signed((NW+1)'(31)));
  assign shifted = t_sum_q[TermN-1] >> sh[4:0];

  always_comb begin
    if (t_sat_q[TermN-1]) begin
      rad_d = RMax;
    end else if (sh_big) begin
      rad_d = '0;
    end else if (shifted > SumW'(RMax)) begin
      rad_d = RMax;
    end else begin
      rad_d = shifted[RadW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= t_vld_q[TermN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o <= rad_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/smts_shade.sv -----
// ----------------------------------------------------------------------------
// smts_shade: visibility and gray level from the raw radius
// Cubes the radius of the star and of index zero, applies the faint cut and
// scales the cube to a gray level. Also prepares the square root argument.
// ----------------------------------------------------------------------------
`default_nettype none

module smts_shade (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              vld_i,
  input  wire logic [smts_pkg::RadW-1:0]   rad_i,
  input  wire logic [smts_pkg::RadW-1:0]   rad0_i,
  output logic                             vld_o,
  output smts_pkg::smts_side_t             side_o,
  output logic [smts_pkg::SqInW-1:0]       sq_arg_o
);
  import smts_pkg::*;

  // Stage 1: squares and range flags.
  logic            s1_vld_q;
  logic [RadW-1:0] s1_rad_q;
  logic [16:0]     s1_rs_q, s1_rs0_q;
  logic [33:0]     s1_sq_q, s1_sq0_q;
  logic            s1_small_q, s1_low_q, s1_small0_q, s1_low0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_rad_q    <= rad_i;
      s1_rs_q     <= rad_i[16:0];
      s1_rs0_q    <= rad0_i[16:0];
      s1_sq_q     <= 34'(rad_i[16:0]) * 34'(rad_i[16:0]);
      s1_sq0_q    <= 34'(rad0_i[16:0]) * 34'(rad0_i[16:0]);
      s1_small_q  <= (rad_i <= RSmall);
      s1_low_q    <= (rad_i <= RMinVis);
      s1_small0_q <= (rad0_i <= RSmall);
      s1_low0_q   <= (rad0_i <= RMinVis);
    end
  end

  // Stage 2: cubes.
  logic            s2_vld_q;
  logic [RadW-1:0] s2_rad_q;
  logic [50:0]     s2_c_q, s2_c0_q;
  logic            s2_small_q, s2_low_q, s2_small0_q, s2_low0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_rad_q    <= s1_rad_q;
      s2_c_q      <= 51'(s1_sq_q) * 51'(s1_rs_q);
      s2_c0_q     <= 51'(s1_sq0_q) * 51'(s1_rs0_q);
      s2_small_q  <= s1_small_q;
      s2_low_q    <= s1_low_q;
      s2_small0_q <= s1_small0_q;
      s2_low0_q   <= s1_low0_q;
    end
  end

  // Stage 3: faint cut on both radii and the scaled cube for the gray level.
  logic        faint, faint0;
  logic [63:0] gray_num;

  assign faint  = s2_low_q |
                  (s2_small_q & ((64'(s2_c_q) * 64'(FaintMul)) < FaintLim));
  assign faint0 = s2_low0_q |
                  (s2_small0_q & ((64'(s2_c0_q) * 64'(FaintMul)) < FaintLim));
  assign gray_num = 64'(s2_c_q) * 64'(GrayMul) + GrayBias;

  logic            s3_vld_q;
  logic [RadW-1:0] s3_rad_q;
  logic [12:0]     s3_v_q;
  logic            s3_vis_q, s3_small_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_rad_q   <= s2_rad_q;
      s3_v_q     <= gray_num[63:51];
      s3_vis_q   <= !faint && !faint0;
      s3_small_q <= s2_small_q;
    end
  end

  // Stage 4: divide by nine, clamp the gray level, form the root argument.
  logic [25:0]      g_prod;
  logic [9:0]       g_div;
  logic [GrayW-1:0] gray;
  logic [RadW-1:0]  excess;

  assign g_prod = 26'(s3_v_q) * 26'(Div9Mul);
  assign g_div  = g_prod[25:16];
  assign gray   = (g_div > 10'd255) ? 8'd255 : g_div[GrayW-1:0];
  assign excess = s3_rad_q - RSeven;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o.vis     <= s3_vis_q;
      side_o.small_r <= s3_small_q;
      side_o.gray    <= gray;
      side_o.rad     <= s3_rad_q;
      sq_arg_o       <= (s3_rad_q > RBig) ? {excess, 16'd0} : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/smts_sqrt.sv -----
// ----------------------------------------------------------------------------
// smts_sqrt: pipelined integer square root
// One root bit per stage, restoring digit-by-digit method; the shading
// result travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module smts_sqrt (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              vld_i,
  input  wire logic [smts_pkg::SqInW-1:0]  x_i,
  input  wire smts_pkg::smts_side_t        side_i,
  output logic                             vld_o,
  output logic [smts_pkg::RootW-1:0]       root_o,
  output smts_pkg::smts_side_t             side_o
);
  import smts_pkg::*;

  localparam int unsigned RemW = RootW + 2;

  logic [RootW:0]     vld_q;
  logic [SqInW-1:0]   x_q    [RootW+1];
  logic [RemW-1:0]    rem_q  [RootW+1];
  logic [RootW-1:0]   root_q [RootW+1];
  smts_side_t         side_q [RootW+1];

  // Stage inputs at index zero.
  assign vld_q[0]  = vld_i;
  assign x_q[0]    = x_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar g = 0; g < RootW; g++) begin : g_step
    logic [RemW+1:0] rem_n;
    logic [RemW+1:0] trial;
    logic            take;

    // Bring down two bits and try to subtract 4*root + 1.
    assign rem_n = {rem_q[g], x_q[g][SqInW-1:SqInW-2]};
    assign trial = {2'b00, root_q[g], 2'b01};
    assign take  = (rem_n >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g+1]    <= {x_q[g][SqInW-3:0], 2'b00};
        rem_q[g+1]  <= take ? RemW'(rem_n - trial) : RemW'(rem_n);
        root_q[g+1] <= {root_q[g][RootW-2:0], take};
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign vld_o  = vld_q[RootW];
  assign root_o = root_q[RootW];
  assign side_o = side_q[RootW];

endmodule

`default_nettype wire

// ----- rtl/core/star_magnitude_to_sprite_core.sv -----
// ----------------------------------------------------------------------------
// star_magnitude_to_sprite_core: star magnitude index to sprite parameters
// Maps a magnitude index to visibility, drawn radius (Q8.8) and gray level.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_i (a magnitude index) and leave on out_o (visible,
// draw_radius, gray_level), both valid/ready channels. Exactly one result
// leaves per accepted item, in order.
// Two registers, the log radius offset and the log radius step, are written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i and must only change while no
// items are in flight.
// One item is taken every cycle while the skid register is empty. The
// pipeline has 54 stages: the log-to-linear conversion (28 stages), the
// shading unit (4 stages), the square root (20 stages, one bit each) and
// the input and output stages.
// When the receiver stalls, the result at the output moves to a skid register
// and the pipeline advances once more; while the skid register is full the
// whole pipeline holds and in_i.ready is low. Nothing is lost or repeated.
// Reset empties the pipeline and returns the registers to an offset of zero
// and a step of -1699.
// ----------------------------------------------------------------------------
`default_nettype none

module star_magnitude_to_sprite_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire smts_pkg::smts_reg_e          cfg_idx_i,
  input  wire logic [smts_pkg::CfgW-1:0]    cfg_wdata_i,
  smts_stream_if.sink                       in_i,
  smts_stream_if.source                     out_o
);
  import smts_pkg::*;

  // Configuration registers.
  logic signed [OffW-1:0]  off_q;
  logic signed [StepW-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      step_q <= -(17'sd1699);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOffset: off_q  <= $signed(cfg_wdata_i[OffW-1:0]);
        RegStep:   step_q <= $signed(cfg_wdata_i[StepW-1:0]);
      endcase
    end
  end

  // Pipeline advance: everything holds while the skid register is full.
  logic en;
  logic skid_vld_q;

  assign en         = !skid_vld_q;
  assign in_i.ready = en;

  // Stage 0: clamp the index and form the log radius.
  logic [IdxW-1:0]        idx_sat;
  logic signed [LnW-1:0]  ln_d;
  logic                   s0_vld_q;
  logic signed [LnW-1:0]  s0_ln_q, s0_ln0_q;

  assign idx_sat = (in_i.data.mag_idx > IndexMax) ? IndexMax : in_i.data.mag_idx;
  assign ln_d    = LnW'(off_q) + LnW'(step_q) * LnW'($signed({1'b0, idx_sat}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_ln_q  <= ln_d;
      s0_ln0_q <= LnW'(off_q);
    end
  end

  // Radius of this star and of index zero.
  logic            exp_vld, exp0_vld;
  logic [RadW-1:0] rad, rad0;

  smts_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s0_vld_q),
    .ln_i   (s0_ln_q),
    .vld_o  (exp_vld),
    .rad_o  (rad)
  );

  smts_exp u_exp0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s0_vld_q),
    .ln_i   (s0_ln0_q),
    .vld_o  (exp0_vld),
    .rad_o  (rad0)
  );

  // Visibility and gray level.
  logic              sh_vld;
  smts_side_t        sh_side;
  logic [SqInW-1:0]  sq_arg;

  smts_shade u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (exp_vld & exp0_vld),
    .rad_i    (rad),
    .rad0_i   (rad0),
    .vld_o    (sh_vld),
    .side_o   (sh_side),
    .sq_arg_o (sq_arg)
  );

  // Radius compression for large stars.
  logic             rt_vld;
  logic [RootW-1:0] root;
  smts_side_t       rt_side;

  smts_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sh_vld),
    .x_i    (sq_arg),
    .side_i (sh_side),
    .vld_o  (rt_vld),
    .root_o (root),
    .side_o (rt_side)
  );

  // Final stage: drawn radius and result assembly.
  logic [RadW:0]    rr;
  logic [RadW:0]    rr_rnd;
  logic [DrawW-1:0] half;
  smts_out_t        res_d;

  assign rr     = (rt_side.rad > RBig) ? ((RadW+1)'(RSeven) + (RadW+1)'(root))
                                       : (RadW+1)'(rt_side.rad);
  assign rr_rnd = rr + (RadW+1)'(256);
  assign half   = rr_rnd[RadW:9];

  always_comb begin
    res_d = '0;
    if (rt_side.vis) begin
      res_d.visible    = 1'b1;
      res_d.gray_level = rt_side.small_r ? rt_side.gray : 8'd255;
      if (rt_side.small_r || (half < HalfMin)) begin
        res_d.draw_radius = HalfMin;
      end else begin
        res_d.draw_radius = half;
      end
    end
  end

  logic      last_vld_q;
  smts_out_t last_q;
  smts_out_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_vld_q <= 1'b0;
    end else if (en) begin
      last_vld_q <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= res_d;
    end
  end

  // Skid register: catches the output item when the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_o.ready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (last_vld_q && !out_o.ready) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q && last_vld_q && !out_o.ready) begin
      skid_q <= last_q;
    end
  end

  assign out_o.valid = skid_vld_q | last_vld_q;
  assign out_o.data  = skid_vld_q ? skid_q : last_q;

`ifndef NO_ASSERTIONS
  // An invisible star carries no radius and no gray level.
  a_invis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.visible |->
      out_o.data.draw_radius == '0 && out_o.data.gray_level == '0)
    else $error("invisible star with nonzero radius or gray level");

  // A visible star is drawn at no less than the minimum radius.
  a_vis_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.visible |-> out_o.data.draw_radius >= HalfMin)
    else $error("visible star below minimum drawn radius");

  // A full skid register stays full until its item is taken.
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_o.ready |=> skid_vld_q && $stable(skid_q))
    else $error("skid register lost its item");

  // While the skid register is full, the input is refused and the output is valid.
  a_ready_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !in_i.ready && out_o.valid)
    else $error("input accepted while pipeline held");
`endif

endmodule

`default_nettype wire
